@@ src/c8alu_pkg.sv @@
// Shared types and constants for the 8-bit CPU ALU with flags.
package c8alu_pkg;

	typedef enum logic [4:0] {
		OP_ADD   = 5'd0,
		OP_ADC   = 5'd1,
		OP_SUB   = 5'd2,
		OP_SBC   = 5'd3,
		OP_AND   = 5'd4,
		OP_XOR   = 5'd5,
		OP_OR    = 5'd6,
		OP_CP    = 5'd7,
		OP_INC   = 5'd8,
		OP_DEC   = 5'd9,
		OP_RLCA  = 5'd10,
		OP_RRCA  = 5'd11,
		OP_RLA   = 5'd12,
		OP_RRA   = 5'd13,
		OP_CPL   = 5'd14,
		OP_SCF   = 5'd15,
		OP_CCF   = 5'd16,
		OP_ADD16 = 5'd17,
		OP_ADDSP = 5'd18,
		OP_INC16 = 5'd19,
		OP_DEC16 = 5'd20
	} op_t;

	typedef enum logic [1:0] {
		CC_NZ = 2'd0,
		CC_Z  = 2'd1,
		CC_NC = 2'd2,
		CC_C  = 2'd3
	} cond_t;

	localparam int unsigned FLAG_Z_BIT = 3;
	localparam int unsigned FLAG_N_BIT = 2;
	localparam int unsigned FLAG_H_BIT = 1;
	localparam int unsigned FLAG_C_BIT = 0;

	localparam int unsigned IN_ITEM_W  = 43;
	localparam int unsigned IN_DATA_W  = 48;
	localparam int unsigned OUT_ITEM_W = 21;
	localparam int unsigned OUT_DATA_W = 24;

	// Declared from the top bit down so that the last field, the operation, lands in the lowest bits.
	typedef struct packed {
		cond_t       condition_code;
		logic [3:0]  flags_in;
		logic [15:0] second_operand;
		logic [15:0] first_operand;
		op_t         operation;
	} in_item_t;

	typedef struct packed {
		logic        condition_met;
		logic [3:0]  flags_out;
		logic [15:0] result;
	} out_item_t;

endpackage

@@ src/c8alu_core.sv @@
// Combinational datapath: operation decode, adders, logic unit, flags and condition test.
module c8alu_core import c8alu_pkg::*; (
	input  in_item_t  item,
	output out_item_t res
);

	logic [7:0]  a;
	logic [7:0]  b;
	logic        cin;
	logic        zin;
	logic        t;
	logic [8:0]  add9;
	logic [4:0]  add5;
	logic [8:0]  sub9;
	logic [4:0]  sub5;
	logic [16:0] add17;
	logic [12:0] add13;
	logic [15:0] sp_sum;
	logic [15:0] r;
	logic [3:0]  f;
	logic        met;

	assign a   = item.first_operand[7:0];
	assign b   = item.second_operand[7:0];
	assign cin = item.flags_in[FLAG_C_BIT];
	assign zin = item.flags_in[FLAG_Z_BIT];
	// Only adc and sbc take the incoming carry into the 8-bit adders.
	assign t   = ((item.operation == OP_ADC) || (item.operation == OP_SBC)) ? cin : 1'b0;

	assign add9   = {1'b0, a} + {1'b0, b} + {8'd0, t};
	assign add5   = {1'b0, a[3:0]} + {1'b0, b[3:0]} + {4'd0, t};
	assign sub9   = {1'b0, a} - {1'b0, b} - {8'd0, t};
	assign sub5   = {1'b0, a[3:0]} - {1'b0, b[3:0]} - {4'd0, t};
	assign add17  = {1'b0, item.first_operand} + {1'b0, item.second_operand};
	assign add13  = {1'b0, item.first_operand[11:0]} + {1'b0, item.second_operand[11:0]};
	assign sp_sum = item.first_operand + {{8{b[7]}}, b};

	always_comb begin
		r = item.first_operand;
		f = item.flags_in;
		case (item.operation)
			OP_ADD, OP_ADC: begin
				r = {8'd0, add9[7:0]};
				f = {add9[7:0] == 8'd0, 1'b0, add5[4], add9[8]};
			end
			OP_SUB, OP_SBC: begin
				r = {8'd0, sub9[7:0]};
				f = {sub9[7:0] == 8'd0, 1'b1, sub5[4], sub9[8]};
			end
			OP_CP: begin
				r = {8'd0, a};
				f = {sub9[7:0] == 8'd0, 1'b1, sub5[4], sub9[8]};
			end
			OP_AND: begin
				r = {8'd0, a & b};
				f = {(a & b) == 8'd0, 1'b0, 1'b1, 1'b0};
			end
			OP_XOR: begin
				r = {8'd0, a ^ b};
				f = {(a ^ b) == 8'd0, 3'b000};
			end
			OP_OR: begin
				r = {8'd0, a | b};
				f = {(a | b) == 8'd0, 3'b000};
			end
			OP_INC: begin
				r = {8'd0, a + 8'd1};
				f = {a == 8'hFF, 1'b0, a[3:0] == 4'hF, cin};
			end
			OP_DEC: begin
				r = {8'd0, a - 8'd1};
				f = {a == 8'h01, 1'b1, a[3:0] == 4'h0, cin};
			end
			OP_RLCA: begin
				r = {8'd0, a[6:0], a[7]};
				f = {3'b000, a[7]};
			end
			OP_RRCA: begin
				r = {8'd0, a[0], a[7:1]};
				f = {3'b000, a[0]};
			end
			OP_RLA: begin
				r = {8'd0, a[6:0], cin};
				f = {3'b000, a[7]};
			end
			OP_RRA: begin
				r = {8'd0, cin, a[7:1]};
				f = {3'b000, a[0]};
			end
			OP_CPL: begin
				r = {8'd0, ~a};
				f = {zin, 1'b1, 1'b1, cin};
			end
			OP_SCF: begin
				r = {8'd0, a};
				f = {zin, 1'b0, 1'b0, 1'b1};
			end
			OP_CCF: begin
				r = {8'd0, a};
				f = {zin, 1'b0, 1'b0, ~cin};
			end
			OP_ADD16: begin
				r = add17[15:0];
				f = {zin, 1'b0, add13[12], add17[16]};
			end
			OP_ADDSP: begin
				// Flags come from the unsigned add of the low byte and the offset byte.
				r = sp_sum;
				f = {2'b00, add5[4], add9[8]};
			end
			OP_INC16: begin
				r = item.first_operand + 16'd1;
			end
			OP_DEC16: begin
				r = item.first_operand - 16'd1;
			end
			default: begin
				r = item.first_operand;
				f = item.flags_in;
			end
		endcase
	end

	always_comb begin
		case (item.condition_code)
			CC_NZ:   met = ~zin;
			CC_Z:    met = zin;
			CC_NC:   met = ~cin;
			CC_C:    met = cin;
			default: met = cin;
		endcase
	end

	assign res.result        = r;
	assign res.flags_out     = f;
	assign res.condition_met = met;

endmodule

@@ src/cpu8_alu_with_flags_top.sv @@
// Top level of the 8-bit CPU ALU with flags: input register, datapath and result register.
//
// Each item carries an operation code, two 16-bit operands, the incoming Z/N/H/C flags
// and a jump condition code, and yields exactly one result item with the result, the
// new flags and the condition test on the incoming flags. An item is latched into an
// input register, evaluated by a single pass of short adders and logic, and captured
// in a result register once that register is free or its result is being taken,
// and the result register presents it on the output.
// One item is accepted every cycle; the input side keeps accepting while a finished
// result waits downstream, and stalls only when both registers are full and the
// waiting result is not taken. There is no state kept between items.
module cpu8_alu_with_flags_top import c8alu_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	// operation[4:0], first_operand[20:5], second_operand[36:21], flags_in[40:37],
	// condition_code[42:41], zero fill[47:43]
	input  logic [IN_DATA_W-1:0]  s_tdata,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	// result[15:0], flags_out[19:16], condition_met[20], zero fill[23:21]
	output logic [OUT_DATA_W-1:0] m_tdata
);

	in_item_t  item_s1;
	logic      valid_s1;
	out_item_t res_comb;
	out_item_t res_s2;
	logic      valid_s2;
	logic      load_s2;
	logic      load_s1;
	logic      byte_op_s1;

	assign load_s2  = valid_s1 && (!valid_s2 || m_tready);
	assign s_tready = !valid_s1 || load_s2;
	assign load_s1  = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (s_tready) begin
				valid_s1 <= s_tvalid;
			end
			if (!valid_s2 || m_tready) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load_s1) begin
			item_s1 <= in_item_t'(s_tdata[IN_ITEM_W-1:0]);
		end
		if (load_s2) begin
			res_s2 <= res_comb;
		end
	end

	c8alu_core u_core (
		.item (item_s1),
		.res  (res_comb)
	);

	assign m_tvalid = valid_s2;
	assign m_tdata  = {{(OUT_DATA_W - OUT_ITEM_W){1'b0}}, res_s2};

	assign byte_op_s1 = item_s1.operation inside {[OP_ADD:OP_CCF]};

	// A held item in the input register must not change while the result side is full.
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !load_s2 |=> valid_s1 && $stable(item_s1))
		else $error("input register changed while stalled");

	// Anything moved into the result register is presented the next cycle.
	a_s2_load: assert property (@(posedge clk) disable iff (!arst_n)
		load_s2 |=> m_tvalid)
		else $error("result lost after load");

	// Byte-wide operations leave the upper result byte clear.
	a_byte_high: assert property (@(posedge clk) disable iff (!arst_n)
		load_s2 && byte_op_s1 |=> res_s2.result[15:8] == 8'd0)
		else $error("8-bit operation produced a nonzero high byte");

	// The 16-bit increment and decrement pass the flags through untouched.
	a_inc16_flags: assert property (@(posedge clk) disable iff (!arst_n)
		load_s2 && (item_s1.operation == OP_INC16 || item_s1.operation == OP_DEC16)
		|=> res_s2.flags_out == $past(item_s1.flags_in))
		else $error("16-bit inc or dec changed the flags");

endmodule

@@ bench/tb_top.sv @@
// Self-checking testbench for the 8-bit CPU ALU with flags, with a directed table and random items.
`timescale 1ns / 1ps

module tb_top;
	import c8alu_pkg::*;

	localparam int unsigned CYCLE_LIMIT  = 200000;
	localparam int unsigned DRAIN_CYCLES = 20;
	localparam int unsigned PHASE_ITEMS  = 500;

	// Operation codes past the last defined one pass the operand and flags through.
	localparam op_t OP_FIRST_UNUSED = op_t'(5'd21);
	localparam op_t OP_LAST_UNUSED  = op_t'(5'd31);

	typedef struct {
		in_item_t  item;
		bit        typed;
		out_item_t want;
	} row_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [IN_DATA_W-1:0]  s_tdata = '0;
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_tdata;

	// The expectation typed into a table row travels along with the item on the bus.
	bit          row_typed = 1'b0;
	out_item_t   row_want = '0;

	out_item_t   alu_expected[$];
	row_t        directed_rows[$];
	int unsigned mismatch_count = 0;
	int unsigned cycle_count = 0;
	int unsigned sender_idle_pct = 8;
	int unsigned sink_idle_pct = 70;

	cpu8_alu_with_flags_top u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	function automatic out_item_t alu_predict(in_item_t it);
		logic [7:0]  a;
		logic [7:0]  b;
		logic [15:0] a16;
		logic [15:0] b16;
		logic        cin;
		logic        zin;
		logic        t;
		logic [8:0]  s9;
		logic [4:0]  h5;
		logic [16:0] s17;
		logic [12:0] h13;
		logic [15:0] r;
		logic [3:0]  f;
		out_item_t   o;
		a   = it.first_operand[7:0];
		b   = it.second_operand[7:0];
		a16 = it.first_operand;
		b16 = it.second_operand;
		cin = it.flags_in[FLAG_C_BIT];
		zin = it.flags_in[FLAG_Z_BIT];
		r   = a16;
		f   = it.flags_in;
		case (it.operation)
			OP_ADD, OP_ADC: begin
				t  = (it.operation == OP_ADC) ? cin : 1'b0;
				s9 = {1'b0, a} + {1'b0, b} + {8'd0, t};
				h5 = {1'b0, a[3:0]} + {1'b0, b[3:0]} + {4'd0, t};
				r  = {8'd0, s9[7:0]};
				f  = '0;
				f[FLAG_H_BIT] = h5[4];
				f[FLAG_C_BIT] = s9[8];
			end
			OP_SUB, OP_SBC, OP_CP: begin
				// The sign bit of the widened difference is the borrow.
				t  = (it.operation == OP_SBC) ? cin : 1'b0;
				s9 = {1'b0, a} - {1'b0, b} - {8'd0, t};
				h5 = {1'b0, a[3:0]} - {1'b0, b[3:0]} - {4'd0, t};
				r  = (it.operation == OP_CP) ? {8'd0, a} : {8'd0, s9[7:0]};
				f  = '0;
				// Compare keeps the accumulator but still takes zero from the difference.
				f[FLAG_Z_BIT] = (s9[7:0] == 8'd0);
				f[FLAG_N_BIT] = 1'b1;
				f[FLAG_H_BIT] = h5[4];
				f[FLAG_C_BIT] = s9[8];
			end
			OP_AND: begin
				r = {8'd0, a & b};
				f = '0;
				f[FLAG_H_BIT] = 1'b1;
			end
			OP_XOR: begin
				r = {8'd0, a ^ b};
				f = '0;
			end
			OP_OR: begin
				r = {8'd0, a | b};
				f = '0;
			end
			OP_INC: begin
				r = {8'd0, a + 8'd1};
				f = '0;
				f[FLAG_H_BIT] = (a[3:0] == 4'hF);
				f[FLAG_C_BIT] = cin;
			end
			OP_DEC: begin
				r = {8'd0, a - 8'd1};
				f = '0;
				f[FLAG_N_BIT] = 1'b1;
				f[FLAG_H_BIT] = (a[3:0] == 4'h0);
				f[FLAG_C_BIT] = cin;
			end
			OP_RLCA, OP_RRCA, OP_RLA, OP_RRA: begin
				f = '0;
				case (it.operation)
					OP_RLCA: r = {8'd0, a[6:0], a[7]};
					OP_RRCA: r = {8'd0, a[0], a[7:1]};
					OP_RLA:  r = {8'd0, a[6:0], cin};
					default: r = {8'd0, cin, a[7:1]};
				endcase
				f[FLAG_C_BIT] = (it.operation == OP_RLCA || it.operation == OP_RLA) ? a[7] : a[0];
			end
			OP_CPL: begin
				r = {8'd0, ~a};
				f[FLAG_N_BIT] = 1'b1;
				f[FLAG_H_BIT] = 1'b1;
			end
			OP_SCF, OP_CCF: begin
				r = {8'd0, a};
				f[FLAG_N_BIT] = 1'b0;
				f[FLAG_H_BIT] = 1'b0;
				f[FLAG_C_BIT] = (it.operation == OP_SCF) ? 1'b1 : ~cin;
			end
			OP_ADD16: begin
				s17 = {1'b0, a16} + {1'b0, b16};
				h13 = {1'b0, a16[11:0]} + {1'b0, b16[11:0]};
				r   = s17[15:0];
				f[FLAG_N_BIT] = 1'b0;
				f[FLAG_H_BIT] = h13[12];
				f[FLAG_C_BIT] = s17[16];
			end
			OP_ADDSP: begin
				// Flags come from the unsigned add of the low byte and the offset byte.
				r  = a16 + {{8{b[7]}}, b};
				s9 = {1'b0, a16[7:0]} + {1'b0, b};
				h5 = {1'b0, a16[3:0]} + {1'b0, b[3:0]};
				f  = '0;
				f[FLAG_H_BIT] = h5[4];
				f[FLAG_C_BIT] = s9[8];
			end
			OP_INC16: r = a16 + 16'd1;
			OP_DEC16: r = a16 - 16'd1;
			default: ;
		endcase
		case (it.operation)
			OP_ADD, OP_ADC, OP_SUB, OP_SBC, OP_AND, OP_XOR, OP_OR, OP_INC, OP_DEC:
				f[FLAG_Z_BIT] = (r[7:0] == 8'd0);
			default: ;
		endcase
		o.result    = r;
		o.flags_out = f;
		case (it.condition_code)
			CC_NZ:   o.condition_met = ~zin;
			CC_Z:    o.condition_met = zin;
			CC_NC:   o.condition_met = ~cin;
			default: o.condition_met = cin;
		endcase
		return o;
	endfunction

	task automatic report_mismatch(string what);
		$display("mismatch at %0t: %s", $realtime, what);
		mismatch_count++;
	endtask

	always @(posedge clk) begin : result_check
		out_item_t got;
		out_item_t want;
		if (arst_n) begin
			if (s_tvalid && s_tready)
				alu_expected.push_back(row_typed ? row_want
					: alu_predict(in_item_t'(s_tdata[IN_ITEM_W-1:0])));
			if (m_tvalid && m_tready) begin
				got = out_item_t'(m_tdata[OUT_ITEM_W-1:0]);
				if (alu_expected.size() == 0) begin
					report_mismatch($sformatf("unexpected result %h", got));
				end else begin
					want = alu_expected.pop_front();
					if (got.result !== want.result)
						report_mismatch($sformatf("result %h, want %h",
							got.result, want.result));
					if (got.flags_out !== want.flags_out)
						report_mismatch($sformatf("flags %b, want %b",
							got.flags_out, want.flags_out));
					if (got.condition_met !== want.condition_met)
						report_mismatch($sformatf("condition %b, want %b",
							got.condition_met, want.condition_met));
				end
			end
		end
	end

	always @(negedge clk) begin
		if (arst_n)
			m_tready <= ($urandom_range(99) >= sink_idle_pct);
	end

	task automatic send_item(in_item_t it, bit typed, out_item_t want);
		@(negedge clk);
		while ($urandom_range(99) < sender_idle_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid  <= 1'b1;
		s_tdata   <= {{(IN_DATA_W-IN_ITEM_W){1'b0}}, it};
		row_typed <= typed;
		row_want  <= want;
		do @(posedge clk); while (!s_tready);
	endtask

	task automatic add_row(op_t op, logic [15:0] a, logic [15:0] b, logic [3:0] fin,
			cond_t cc);
		row_t row;
		row.item  = '{condition_code: cc, flags_in: fin, second_operand: b,
			first_operand: a, operation: op};
		row.typed = 1'b0;
		row.want  = '0;
		directed_rows.push_back(row);
	endtask

	task automatic add_typed(op_t op, logic [15:0] a, logic [15:0] b, logic [3:0] fin,
			cond_t cc, logic [15:0] res, logic [3:0] fout, logic met);
		add_row(op, a, b, fin, cc);
		directed_rows[$].typed = 1'b1;
		directed_rows[$].want  = '{condition_met: met, flags_out: fout, result: res};
	endtask

	// Operands lean toward the values where carries and zero results happen.
	function automatic logic [15:0] operand_word();
		case ($urandom_range(7))
			0: return 16'h0000;
			1: return 16'hFFFF;
			2: return {8'($urandom), 8'h00};
			3: return {8'($urandom), 8'hFF};
			4: return {8'($urandom), 8'h7F};
			5: return {8'($urandom), 8'h80};
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic in_item_t random_item();
		in_item_t it;
		if ($urandom_range(9) == 0)
			it.operation = op_t'($urandom_range(OP_LAST_UNUSED, OP_FIRST_UNUSED));
		else
			it.operation = op_t'($urandom_range(OP_DEC16, OP_ADD));
		it.first_operand  = operand_word();
		it.second_operand = operand_word();
		it.flags_in       = 4'($urandom);
		it.condition_code = cond_t'($urandom_range(CC_C, CC_NZ));
		return it;
	endfunction

	task automatic wait_results();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (alu_expected.size() != 0)
			@(posedge clk);
	endtask

	task automatic random_phase(int unsigned src_pct, int unsigned snk_pct);
		sender_idle_pct = src_pct;
		sink_idle_pct   = snk_pct;
		for (int unsigned i = 0; i < PHASE_ITEMS; i++)
			send_item(random_item(), 1'b0, '0);
		wait_results();
	endtask

	initial begin
		// Expectations read straight off the flag rules; the rest go to the predictor.
		add_typed(OP_ADD,   16'h0000, 16'h0000, 4'b0000, CC_NZ, 16'h0000, 4'b1000, 1'b1);
		add_typed(OP_ADD,   16'h00FF, 16'h0001, 4'b1111, CC_Z,  16'h0000, 4'b1011, 1'b1);
		add_typed(OP_ADC,   16'h00FF, 16'h0000, 4'b0001, CC_C,  16'h0000, 4'b1011, 1'b1);
		add_typed(OP_SUB,   16'h0000, 16'h0001, 4'b0000, CC_NC, 16'h00FF, 4'b0111, 1'b1);
		add_typed(OP_AND,   16'h00FF, 16'hFF00, 4'b0000, CC_C,  16'h0000, 4'b1010, 1'b0);
		add_typed(OP_CP,    16'h123C, 16'h003C, 4'b0000, CC_Z,  16'h003C, 4'b1100, 1'b0);
		add_typed(OP_INC,   16'h00FF, 16'h1234, 4'b0001, CC_NZ, 16'h0000, 4'b1011, 1'b1);
		add_typed(OP_DEC,   16'h0000, 16'h0000, 4'b1000, CC_Z,  16'h00FF, 4'b0110, 1'b1);
		add_typed(OP_ADD16, 16'hFFFF, 16'h0001, 4'b1000, CC_NC, 16'h0000, 4'b1011, 1'b1);
		add_typed(OP_INC16, 16'hFFFF, 16'h0000, 4'b0101, CC_C,  16'h0000, 4'b0101, 1'b1);
		add_typed(OP_DEC16, 16'h0000, 16'hFFFF, 4'b1010, CC_NZ, 16'hFFFF, 4'b1010, 1'b0);
		add_typed(OP_FIRST_UNUSED, 16'hBEEF, 16'h1234, 4'b0110, CC_NC,
			16'hBEEF, 4'b0110, 1'b1);
		add_typed(OP_LAST_UNUSED, 16'hFFFF, 16'hFFFF, 4'b1111, CC_C,
			16'hFFFF, 4'b1111, 1'b1);
		add_row(OP_ADC,   16'h000F, 16'h0000, 4'b0001, CC_NZ);
		add_row(OP_SBC,   16'h0010, 16'h000F, 4'b0001, CC_Z);
		add_row(OP_SBC,   16'hFF00, 16'hFFFF, 4'b0001, CC_NC);
		add_row(OP_XOR,   16'h0055, 16'h00AA, 4'b1111, CC_C);
		add_row(OP_OR,    16'hFF00, 16'hFF00, 4'b0000, CC_NZ);
		add_row(OP_RLCA,  16'h0080, 16'h0000, 4'b1110, CC_Z);
		add_row(OP_RRCA,  16'h0001, 16'h0000, 4'b0000, CC_NC);
		add_row(OP_RLA,   16'h0080, 16'h0000, 4'b0000, CC_C);
		add_row(OP_RRA,   16'h0001, 16'h0000, 4'b0001, CC_NZ);
		add_row(OP_CPL,   16'h005A, 16'hFFFF, 4'b1001, CC_Z);
		add_row(OP_SCF,   16'hA5C3, 16'h0000, 4'b1110, CC_NC);
		add_row(OP_CCF,   16'h00C3, 16'h0000, 4'b0001, CC_C);
		add_row(OP_ADDSP, 16'h00FF, 16'hAB01, 4'b1111, CC_NZ);
		add_row(OP_ADDSP, 16'h1000, 16'h0080, 4'b0000, CC_Z);

		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		foreach (directed_rows[i])
			send_item(directed_rows[i].item, directed_rows[i].typed, directed_rows[i].want);
		random_phase(8, 70);
		random_phase(70, 8);
		random_phase(0, 0);

		repeat (DRAIN_CYCLES) @(posedge clk);
		if (alu_expected.size() != 0)
			report_mismatch($sformatf("%0d results never arrived", alu_expected.size()));
		if (mismatch_count == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
